/* hw/rtl/etk_pkg.sv */
// Package for the elite top-k insertion list.
// Holds the item structs, request codes, the list entry type and the default depth.
// No dependencies.
package etk_pkg;

	localparam int ELITE_DEPTH = 8;
	localparam int KEY_W = 32;
	localparam int ID_W = 6;

	localparam logic [1:0] REQ_OFFER = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic signed [KEY_W-1:0] cand_key;
		logic [ID_W-1:0] cand_id;
		logic [2:0] read_slot;
	} req_t;

	typedef struct packed {
		logic accepted;
		logic duplicate;
		logic [2:0] insert_pos;
		logic signed [KEY_W-1:0] best_key;
		logic [ID_W-1:0] best_id;
		logic best_valid;
		logic signed [KEY_W-1:0] slot_key;
		logic [ID_W-1:0] slot_id;
		logic slot_valid;
	} rsp_t;

	typedef struct packed {
		logic valid;
		logic signed [KEY_W-1:0] key;
		logic [ID_W-1:0] id;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic clr;
	} cell_ctrl_t;

endpackage

/* hw/rtl/etk_cell.sv */
// One position of the sorted elite list.
// Compares the offered key with its own entry and takes either the candidate or
// its better neighbor's entry on insertion. Depends on etk_pkg.
module etk_cell (
	input logic clk,
	input logic arst_n,
	input etk_pkg::cell_ctrl_t ctrl,
	input logic signed [etk_pkg::KEY_W-1:0] cand_key,
	input logic [etk_pkg::ID_W-1:0] cand_id,
	input etk_pkg::entry_t left,
	input logic left_lt,
	output etk_pkg::entry_t entry,
	output etk_pkg::entry_t entry_nxt,
	output logic lt,
	output logic eq
);
	import etk_pkg::*;

	entry_t entry_q;
	entry_t entry_d;

	assign lt = !entry_q.valid || (cand_key < entry_q.key);
	assign eq = entry_q.valid && (cand_key == entry_q.key);

	always_comb begin
		entry_d = entry_q;
		if (ctrl.clr) begin
			entry_d = '0;
		end else if (ctrl.ins && lt) begin
			if (left_lt) begin
				entry_d = left;
			end else begin
				entry_d.valid = 1'b1;
				entry_d.key = cand_key;
				entry_d.id = cand_id;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= entry_d;
		end
	end

	assign entry = entry_q;
	assign entry_nxt = entry_d;

endmodule

/* hw/rtl/elite_top_k_insert.sv */
// Top level of the elite top-k insertion list.
// Builds a chain of etk_cell positions and a registered result stage. Depends on etk_pkg.
//
// The block keeps the DEPTH lowest keys offered so far, sorted, position 0 being best.
// Requests arrive on req (req_valid/req_ready), one result item per request leaves on
// rsp (rsp_valid/rsp_ready). An offer is compared against every position at once; each
// position either keeps its entry, takes the candidate, or takes its better neighbor's
// entry, so the worst entry drops off the end. An equal stored key rejects the offer as
// a duplicate. A clear empties every position; a read returns one position unchanged.
// Every result also carries the champion as it stands after the request.
// The result is registered: it is valid in the cycle after the request is taken.
// Throughput is one item per cycle while rsp_ready stays high; the cell chain updates at once.
// Reset empties the list and drops any pending result. While a result waits and the
// receiver holds rsp_ready low, req_ready is low and the list does not change.
module elite_top_k_insert #(
	parameter int DEPTH = etk_pkg::ELITE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input etk_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output etk_pkg::rsp_t rsp
);
	import etk_pkg::*;

	localparam int RD_N = (DEPTH < 8) ? DEPTH : 8;

	entry_t cell_q [DEPTH];
	entry_t cell_d [DEPTH];
	logic [DEPTH-1:0] lt;
	logic [DEPTH-1:0] eq;
	logic [DEPTH-1:0] valid_vec;
	logic [DEPTH-1:0] order_ok;
	cell_ctrl_t ctrl;
	logic take;
	logic dup;
	logic [2:0] pos;
	rsp_t rsp_d;
	rsp_t rsp_q;
	logic rsp_valid_q;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign take = req_valid && req_ready;
	assign dup = |eq;

	assign ctrl.clr = take && (req.req_type == REQ_CLEAR);
	assign ctrl.ins = take && (req.req_type == REQ_OFFER) && !dup && lt[DEPTH-1];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			etk_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctrl(ctrl),
				.cand_key(req.cand_key),
				.cand_id(req.cand_id),
				.left('0),
				.left_lt(1'b0),
				.entry(cell_q[i]),
				.entry_nxt(cell_d[i]),
				.lt(lt[i]),
				.eq(eq[i])
			);
			assign order_ok[i] = 1'b1;
		end else begin : g_body
			etk_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctrl(ctrl),
				.cand_key(req.cand_key),
				.cand_id(req.cand_id),
				.left(cell_q[i-1]),
				.left_lt(lt[i-1]),
				.entry(cell_q[i]),
				.entry_nxt(cell_d[i]),
				.lt(lt[i]),
				.eq(eq[i])
			);
			assign order_ok[i] = !cell_q[i].valid || (cell_q[i-1].key < cell_q[i].key);
		end
		assign valid_vec[i] = cell_q[i].valid;
	end

	always_comb begin
		pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (lt[i] && ((i == 0) || !lt[(i == 0) ? 0 : i-1])) begin
				pos = pos | 3'(i);
			end
		end
	end

	always_comb begin
		rsp_d = '0;
		if (req.req_type == REQ_OFFER) begin
			rsp_d.accepted = ctrl.ins;
			rsp_d.duplicate = dup;
			rsp_d.insert_pos = ctrl.ins ? pos : 3'd0;
		end
		if (cell_d[0].valid) begin
			rsp_d.best_key = cell_d[0].key;
			rsp_d.best_id = cell_d[0].id;
			rsp_d.best_valid = 1'b1;
		end
		if (req.req_type == REQ_READ) begin
			for (int i = 0; i < RD_N; i++) begin
				if ((req.read_slot == 3'(i)) && cell_q[i].valid) begin
					rsp_d.slot_key = cell_q[i].key;
					rsp_d.slot_id = cell_q[i].id;
					rsp_d.slot_valid = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// Entries stay packed at the front of the list and in strictly ascending order.
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + 1'b1)) == '0)
		else $error("elite list has a gap");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		&order_ok)
		else $error("elite list out of order");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.accepted && rsp.duplicate))
		else $error("result both accepted and duplicate");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clr |=> (valid_vec == '0) && !rsp.best_valid)
		else $error("clear left entries behind");

endmodule
